// File: rtl/light_seeking_turn_controller_defines.svh
// Assertion macros for the light-seeking turn controller.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LIGHT_SEEKING_TURN_CONTROLLER_DEFINES_SVH
`define LIGHT_SEEKING_TURN_CONTROLLER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LSTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lstc_pkg.sv
// Shared types and constants of the light-seeking turn controller.
// No dependencies; the lane, merge and top-level modules and the testbench import this package.
package lstc_pkg;

	localparam int SAMPLE_W = 10;
	localparam int RANGE_W = 16;
	localparam int N_CHAN = 8;
	localparam int N_BOARD = 4;
	localparam int CFG_IDX_W = $clog2(N_CHAN);
	localparam int BOARD_IDX_W = $clog2(N_BOARD);
	localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
	localparam int RANGE_SPAN_MAX = (2 ** RANGE_W) - 1;
	localparam int DEFAULT_FULL_SCALE = 1023;
	localparam int GAP_STOP = 5;
	localparam int GAP_START = 30;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_STOP = 2'd1,
		ACT_RUN = 2'd2
	} motor_act_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_0;
		logic [SAMPLE_W-1:0] sample_1;
		logic [SAMPLE_W-1:0] sample_2;
		logic [SAMPLE_W-1:0] sample_3;
		logic [SAMPLE_W-1:0] sample_4;
		logic [SAMPLE_W-1:0] sample_5;
		logic [SAMPLE_W-1:0] sample_6;
		logic [SAMPLE_W-1:0] sample_7;
	} sample_word_t;

	typedef struct packed {
		motor_act_t left_motor_action;
		motor_act_t right_motor_action;
		logic [BOARD_IDX_W-1:0] brightest_board;
		logic left_running;
		logic right_running;
	} result_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [2*RANGE_W-1:0] value;
	} cfg_word_t;

	// Load enables of the four lane stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} lane_en_t;

	// Load enables of the merge stages and the flag update strobe.
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
		logic upd;
	} merge_ctl_t;

endpackage

// File: rtl/lstc_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Used for the sample, configuration and result channels.
interface lstc_stream_if #(parameter type payload_t = logic);

	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// File: rtl/lstc_lane.sv
// One mapping lane: scales a 10-bit sample onto its channel's calibrated range.
// Four stages; the division by the full scale is a reciprocal multiply and one correction.
module lstc_lane import lstc_pkg::*; #(
	parameter int SAMPLE_FULL_SCALE = DEFAULT_FULL_SCALE,
	parameter int MAG_W = 16,
	parameter int MAP_W = 18
) (
	input logic clk,
	input lane_en_t en,
	input logic [SAMPLE_W-1:0] sample,
	input logic [2*RANGE_W-1:0] chan_range,
	output logic signed [MAP_W-1:0] mapped
);

	localparam int PROD_W = SAMPLE_W + RANGE_W;
	localparam longint RECIP = (longint'(1) << PROD_W) / SAMPLE_FULL_SCALE;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam int FS_W = $clog2(SAMPLE_FULL_SCALE + 1);
	localparam int REM_W = FS_W + 1;

	logic signed [RANGE_W-1:0] lo;
	logic signed [RANGE_W-1:0] hi;
	logic signed [RANGE_W:0] span;
	logic [RANGE_W:0] span_neg;
	logic [RANGE_W-1:0] span_mag;

	logic [PROD_W-1:0] mag_s1;
	logic neg_s1;
	logic signed [RANGE_W-1:0] lo_s1;

	logic [PROD_W+RECIP_W-1:0] recip_prod;
	logic [PROD_W-1:0] mag_s2;
	logic [MAG_W-1:0] q0_s2;
	logic neg_s2;
	logic signed [RANGE_W-1:0] lo_s2;

	logic [PROD_W-1:0] qfs;
	logic [PROD_W-1:0] rem;
	logic [REM_W-1:0] rem_s3;
	logic [MAG_W-1:0] q0_s3;
	logic neg_s3;
	logic signed [RANGE_W-1:0] lo_s3;

	logic [MAG_W-1:0] quo;
	logic signed [MAP_W-1:0] quo_ext;
	logic signed [MAP_W-1:0] quo_signed;
	logic signed [MAP_W-1:0] mapped_s4;

	assign lo = chan_range[RANGE_W-1:0];
	assign hi = chan_range[2*RANGE_W-1:RANGE_W];
	assign span = {hi[RANGE_W-1], hi} - {lo[RANGE_W-1], lo};
	assign span_neg = -span;
	assign span_mag = span[RANGE_W] ? span_neg[RANGE_W-1:0] : span[RANGE_W-1:0];

	// Work on the magnitude so that the quotient truncates toward zero.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			mag_s1 <= {{RANGE_W{1'b0}}, sample} * {{SAMPLE_W{1'b0}}, span_mag};
			neg_s1 <= span[RANGE_W];
			lo_s1 <= lo;
		end
	end

	// The reciprocal estimate is at most one below the true quotient.
	assign recip_prod = {{RECIP_W{1'b0}}, mag_s1} * {{PROD_W{1'b0}}, RECIP_C};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			q0_s2 <= recip_prod[PROD_W +: MAG_W];
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			lo_s2 <= lo_s1;
		end
	end

	assign qfs = {{(PROD_W-MAG_W){1'b0}}, q0_s2} * PROD_W'(SAMPLE_FULL_SCALE);
	assign rem = mag_s2 - qfs;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rem_s3 <= rem[REM_W-1:0];
			q0_s3 <= q0_s2;
			neg_s3 <= neg_s2;
			lo_s3 <= lo_s2;
		end
	end

	assign quo = q0_s3 + MAG_W'(rem_s3 >= REM_W'(SAMPLE_FULL_SCALE));
	assign quo_ext = {{(MAP_W-MAG_W){1'b0}}, quo};
	assign quo_signed = neg_s3 ? -quo_ext : quo_ext;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			mapped_s4 <= quo_signed + {{(MAP_W-RANGE_W){lo_s3[RANGE_W-1]}}, lo_s3};
		end
	end

	assign mapped = mapped_s4;

endmodule

// File: rtl/lstc_merge.sv
// Merge stage: sums channel pairs into boards, picks the brightest board,
// and runs the motor hysteresis. Holds the two running flags.
module lstc_merge import lstc_pkg::*; #(
	parameter int MAP_W = 18
) (
	input logic clk,
	input logic arst_n,
	input merge_ctl_t ctl,
	input logic signed [MAP_W-1:0] mapped [N_CHAN],
	output result_word_t res
);

	localparam int BW = MAP_W + 1;

	logic signed [BW-1:0] board_s5 [N_BOARD];

	logic [BOARD_IDX_W-1:0] best;
	logic signed [BW-1:0] best_val;
	logic signed [BW-1:0] left_val;
	logic signed [BW-1:0] right_val;

	logic [BOARD_IDX_W-1:0] m_s6;
	logic signed [BW-1:0] bm_s6;
	logic signed [BW-1:0] bl_s6;
	logic signed [BW-1:0] br_s6;

	logic right_side;
	logic signed [BW-1:0] near_val;
	logic [BW:0] gap;
	logic gap_small;
	logic gap_large;
	motor_act_t left_act;
	motor_act_t right_act;
	logic left_next;
	logic right_next;

	logic left_on_q;
	logic right_on_q;
	result_word_t res_s7;

	always_ff @(posedge clk) begin
		if (ctl.s5) begin
			for (int k = 0; k < N_BOARD; k++) begin
				board_s5[k] <= $signed({mapped[2*k][MAP_W-1], mapped[2*k]}) +
					$signed({mapped[2*k+1][MAP_W-1], mapped[2*k+1]});
			end
		end
	end

	// Later boards win ties, so the compare is greater-or-equal.
	always_comb begin
		best = '0;
		best_val = board_s5[0];
		for (int k = 1; k < N_BOARD; k++) begin
			if (board_s5[k] >= best_val) begin
				best = BOARD_IDX_W'(k);
				best_val = board_s5[k];
			end
		end
	end

	always_comb begin
		case (best)
			2'd0: begin
				left_val = board_s5[3];
				right_val = board_s5[1];
			end
			2'd1: begin
				left_val = board_s5[0];
				right_val = board_s5[2];
			end
			2'd2: begin
				left_val = board_s5[1];
				right_val = board_s5[3];
			end
			default: begin
				left_val = board_s5[2];
				right_val = board_s5[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.s6) begin
			m_s6 <= best;
			bm_s6 <= best_val;
			bl_s6 <= left_val;
			br_s6 <= right_val;
		end
	end

	assign right_side = br_s6 >= bl_s6;
	assign near_val = right_side ? br_s6 : bl_s6;
	// The chosen board is the maximum, so the gap is never negative.
	assign gap = {bm_s6[BW-1], bm_s6} - {near_val[BW-1], near_val};
	assign gap_small = gap < (BW+1)'(GAP_STOP);
	assign gap_large = gap > (BW+1)'(GAP_START);

	// The stop sent to the opposite motor leaves its running flag alone.
	always_comb begin
		left_act = ACT_NONE;
		right_act = ACT_NONE;
		left_next = left_on_q;
		right_next = right_on_q;
		if (right_side) begin
			if (left_on_q) begin
				left_act = ACT_STOP;
			end
			if (right_on_q) begin
				if (gap_small) begin
					right_act = ACT_STOP;
					right_next = 1'b0;
				end
			end else if (gap_large) begin
				right_act = ACT_RUN;
				right_next = 1'b1;
			end
		end else begin
			if (right_on_q) begin
				right_act = ACT_STOP;
			end
			if (left_on_q) begin
				if (gap_small) begin
					left_act = ACT_STOP;
					left_next = 1'b0;
				end
			end else if (gap_large) begin
				left_act = ACT_RUN;
				left_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_on_q <= 1'b0;
			right_on_q <= 1'b0;
		end else if (ctl.upd) begin
			left_on_q <= left_next;
			right_on_q <= right_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s7) begin
			res_s7.left_motor_action <= left_act;
			res_s7.right_motor_action <= right_act;
			res_s7.brightest_board <= m_s6;
			res_s7.left_running <= left_next;
			res_s7.right_running <= right_next;
		end
	end

	assign res = res_s7;

endmodule

// File: rtl/light_seeking_turn_controller.sv
// Channel   | Role   | Word
// samples   | sink   | sample_word_t: eight 10-bit light readings
// cfg       | sink   | cfg_word_t: channel index and packed low/high range
// results   | source | result_word_t: motor actions, brightest board, running flags
//
// One word per cycle is accepted unless the results channel stalls; a result passes
// through four lane stages (multiply, reciprocal multiply, correction, offset)
// and three merge stages (board sums, argmax, hysteresis and output register).
// Reset clears the range registers, the running flags and the stage valids.
// A full stage holds while the stage after it is full and stalled, so bubbles close up.
// The configuration port is always ready and takes a write in the cycle it is offered.
`include "light_seeking_turn_controller_defines.svh"

module light_seeking_turn_controller import lstc_pkg::*; #(
	parameter int SAMPLE_FULL_SCALE = DEFAULT_FULL_SCALE
) (
	input logic clk,
	input logic arst_n,
	lstc_stream_if.sink samples,
	lstc_stream_if.sink cfg,
	lstc_stream_if.source results
);

	localparam int MAG_W = $clog2(SAMPLE_MAX * RANGE_SPAN_MAX / SAMPLE_FULL_SCALE + 1);
	localparam int MAP_W = ((MAG_W > RANGE_W - 1) ? MAG_W : RANGE_W - 1) + 2;
	localparam int N_STAGE = 7;

	logic [2*RANGE_W-1:0] range_q [N_CHAN];
	logic [SAMPLE_W-1:0] smp [N_CHAN];
	logic signed [MAP_W-1:0] mapped [N_CHAN];

	logic [N_STAGE:1] vld_q;
	logic [N_STAGE:1] vld_in;
	logic [N_STAGE:1] en;
	lane_en_t lane_en;
	merge_ctl_t merge_ctl;
	result_word_t res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < N_CHAN; c++) begin
				range_q[c] <= '0;
			end
		end else if (cfg.valid) begin
			range_q[cfg.data.index] <= cfg.data.value;
		end
	end

	// A stage loads when it is empty or when its contents move on.
	always_comb begin
		en[N_STAGE] = !vld_q[N_STAGE] || results.ready;
		for (int k = N_STAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in = {vld_q[N_STAGE-1:1], samples.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & en) | (vld_q & ~en);
		end
	end

	assign samples.ready = en[1];

	assign lane_en.s1 = en[1];
	assign lane_en.s2 = en[2];
	assign lane_en.s3 = en[3];
	assign lane_en.s4 = en[4];
	assign merge_ctl.s5 = en[5];
	assign merge_ctl.s6 = en[6];
	assign merge_ctl.s7 = en[7];
	assign merge_ctl.upd = en[7] && vld_q[6];

	assign smp[0] = samples.data.sample_0;
	assign smp[1] = samples.data.sample_1;
	assign smp[2] = samples.data.sample_2;
	assign smp[3] = samples.data.sample_3;
	assign smp[4] = samples.data.sample_4;
	assign smp[5] = samples.data.sample_5;
	assign smp[6] = samples.data.sample_6;
	assign smp[7] = samples.data.sample_7;

	for (genvar c = 0; c < N_CHAN; c++) begin : g_lane
		lstc_lane #(
			.SAMPLE_FULL_SCALE(SAMPLE_FULL_SCALE),
			.MAG_W(MAG_W),
			.MAP_W(MAP_W)
		) u_lane (
			.clk(clk),
			.en(lane_en),
			.sample(smp[c]),
			.chan_range(range_q[c]),
			.mapped(mapped[c])
		);
	end

	lstc_merge #(
		.MAP_W(MAP_W)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(merge_ctl),
		.mapped(mapped),
		.res(res)
	);

	assign results.valid = vld_q[N_STAGE];
	assign results.data = res;

	`LSTC_ASSERT_NOW(a_right_run_flag, results.valid && results.data.right_motor_action == ACT_RUN, results.data.right_running, "right run without running flag")
	`LSTC_ASSERT_NOW(a_left_run_flag, results.valid && results.data.left_motor_action == ACT_RUN, results.data.left_running, "left run without running flag")
	`LSTC_ASSERT_NOW(a_single_run, results.valid, !(results.data.left_motor_action == ACT_RUN && results.data.right_motor_action == ACT_RUN), "both motors started")
	`LSTC_ASSERT_NEXT(a_drain, results.valid && results.ready && !vld_q[6], !results.valid, "result word repeated")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the light-seeking turn controller: drives sample words and range writes,
// predicts every result word and checks it. Depends on lstc_pkg, lstc_stream_if and the RTL.

module tb_top;
	import lstc_pkg::*;

	typedef enum int {
		RANGE_IDENTITY,
		RANGE_WORDS,
		RANGE_EXTREME,
		RANGE_NARROW
	} range_style_t;

	// Expected-result store with its own copy of the ranges and running flags.
	class turn_checker;
		bit [2*RANGE_W-1:0] chan_range [N_CHAN];
		bit left_on;
		bit right_on;
		result_word_t pending_turns [$];
		int fail_count;
		int checked;
		int run_count;
		int stop_count;

		function void write_range(int unsigned idx, bit [2*RANGE_W-1:0] value);
			if (idx < N_CHAN)
				chan_range[idx] = value;
		endfunction

		function longint map_sample(int ch, logic [SAMPLE_W-1:0] x);
			longint lo;
			longint hi;
			lo = longint'($signed(chan_range[ch][RANGE_W-1:0]));
			hi = longint'($signed(chan_range[ch][2*RANGE_W-1:RANGE_W]));
			// Signed division truncates toward zero, as the mapping requires.
			return (longint'(x) * (hi - lo)) / longint'(DEFAULT_FULL_SCALE) + lo;
		endfunction

		function void note_samples(sample_word_t w);
			logic [SAMPLE_W-1:0] s [N_CHAN];
			longint board [N_BOARD];
			int m;
			int l;
			int r;
			result_word_t e;
			s = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3,
				w.sample_4, w.sample_5, w.sample_6, w.sample_7};
			for (int k = 0; k < N_BOARD; k++)
				board[k] = map_sample(2 * k, s[2 * k]) + map_sample(2 * k + 1, s[2 * k + 1]);
			m = 0;
			for (int k = 1; k < N_BOARD; k++)
				if (board[k] >= board[m])
					m = k;
			l = (m + N_BOARD - 1) % N_BOARD;
			r = (m + 1) % N_BOARD;
			e.left_motor_action = ACT_NONE;
			e.right_motor_action = ACT_NONE;
			// The motor on the far side, if running, gets a stop pulse but keeps its running flag.
			if (board[r] >= board[l]) begin
				if (left_on)
					e.left_motor_action = ACT_STOP;
				if (right_on) begin
					if (board[m] - board[r] < GAP_STOP) begin
						e.right_motor_action = ACT_STOP;
						right_on = 0;
					end
				end else if (board[m] - board[r] > GAP_START) begin
					e.right_motor_action = ACT_RUN;
					right_on = 1;
				end
			end else begin
				if (right_on)
					e.right_motor_action = ACT_STOP;
				if (left_on) begin
					if (board[m] - board[l] < GAP_STOP) begin
						e.left_motor_action = ACT_STOP;
						left_on = 0;
					end
				end else if (board[m] - board[l] > GAP_START) begin
					e.left_motor_action = ACT_RUN;
					left_on = 1;
				end
			end
			e.brightest_board = m[BOARD_IDX_W-1:0];
			e.left_running = left_on;
			e.right_running = right_on;
			pending_turns.push_back(e);
		endfunction

		function void check_turn(result_word_t got);
			result_word_t e;
			checked++;
			if (pending_turns.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR: result word %0d arrived with none expected (%0h)",
						checked, got);
				return;
			end
			e = pending_turns.pop_front();
			run_count += (e.left_motor_action == ACT_RUN) + (e.right_motor_action == ACT_RUN);
			stop_count += (e.left_motor_action == ACT_STOP) + (e.right_motor_action == ACT_STOP);
			if (got.left_motor_action !== e.left_motor_action ||
					got.right_motor_action !== e.right_motor_action ||
					got.brightest_board !== e.brightest_board ||
					got.left_running !== e.left_running ||
					got.right_running !== e.right_running) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("ERROR: result word %0d: expected L%0d R%0d board %0d run %0b%0b",
						checked, e.left_motor_action, e.right_motor_action,
						e.brightest_board, e.left_running, e.right_running);
					$display("       got L%0d R%0d board %0d run %0b%0b",
						got.left_motor_action, got.right_motor_action,
						got.brightest_board, got.left_running, got.right_running);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold;
	int range_sets;
	turn_checker sb = new();

	lstc_stream_if #(.payload_t(sample_word_t)) sample_ch ();
	lstc_stream_if #(.payload_t(cfg_word_t)) cfg_ch ();
	lstc_stream_if #(.payload_t(result_word_t)) result_ch ();

	light_seeking_turn_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.cfg(cfg_ch),
		.results(result_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_range(cfg_ch.data.index, cfg_ch.data.value);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_samples(sample_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_turn(result_ch.data);
		end
	end

	function automatic sample_word_t pack_samples(input int s [N_CHAN]);
		sample_word_t w;
		w.sample_0 = SAMPLE_W'(s[0]);
		w.sample_1 = SAMPLE_W'(s[1]);
		w.sample_2 = SAMPLE_W'(s[2]);
		w.sample_3 = SAMPLE_W'(s[3]);
		w.sample_4 = SAMPLE_W'(s[4]);
		w.sample_5 = SAMPLE_W'(s[5]);
		w.sample_6 = SAMPLE_W'(s[6]);
		w.sample_7 = SAMPLE_W'(s[7]);
		return w;
	endfunction

	// Most words cluster around one level so that board gaps land near the
	// start and stop thresholds; the rest are fully random or have each sample at full scale or zero.
	function automatic sample_word_t make_samples();
		int s [N_CHAN];
		int mode;
		int base;
		int spread;
		mode = $urandom_range(99);
		base = $urandom_range(SAMPLE_MAX);
		case ($urandom_range(4))
			0: spread = 0;
			1: spread = 2;
			2: spread = 8;
			3: spread = 24;
			default: spread = 64;
		endcase
		for (int i = 0; i < N_CHAN; i++) begin
			if (mode < 30) begin
				s[i] = $urandom_range(SAMPLE_MAX);
			end else if (mode < 36) begin
				s[i] = $urandom_range(1) ? SAMPLE_MAX : 0;
			end else begin
				s[i] = base + int'($urandom_range(spread)) - spread / 2;
				if (s[i] < 0)
					s[i] = 0;
				if (s[i] > SAMPLE_MAX)
					s[i] = SAMPLE_MAX;
			end
		end
		return pack_samples(s);
	endfunction

	// Leaves valid high on return, unless it idled, so that back-to-back words need no toggle.
	task automatic send_samples(sample_word_t w);
		sample_ch.valid <= 1'b1;
		sample_ch.data <= w;
		do @(posedge clk); while (!sample_ch.ready);
		// Each cycle after a word is idle with the chosen odds, so idle cycles
		// make up that share of the sender's time.
		if ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic send_boards(int b0, int b1, int b2, int b3);
		int b [N_BOARD];
		int s [N_CHAN];
		b = '{b0, b1, b2, b3};
		for (int k = 0; k < N_BOARD; k++) begin
			s[2 * k] = b[k] / 2;
			s[2 * k + 1] = b[k] - b[k] / 2;
		end
		send_samples(pack_samples(s));
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++)
			send_samples(make_samples());
		sample_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (sb.pending_turns.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic load_ranges(range_style_t style);
		cfg_word_t w;
		int lo;
		int hi;
		for (int i = 0; i < N_CHAN; i++) begin
			case (style)
				RANGE_IDENTITY: begin
					lo = 0;
					hi = SAMPLE_MAX;
				end
				RANGE_EXTREME: begin
					lo = ((i % 2) ^ $urandom_range(1)) ? 32767 : -32768;
					hi = -lo - 1;
				end
				RANGE_NARROW: begin
					lo = int'($urandom_range(400)) - 200;
					hi = lo + int'($urandom_range(120)) - 30;
				end
				default: begin
					lo = $urandom;
					hi = $urandom;
				end
			endcase
			w.index = CFG_IDX_W'(i);
			w.value = {hi[RANGE_W-1:0], lo[RANGE_W-1:0]};
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= w;
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		range_sets++;
	endtask

	task automatic hold_receiver(int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		rx_hold = 1'b0;
		tx_idle_pct = 34;
		rx_idle_pct = 46;
		range_sets = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All ranges are zero out of reset, so every board ties at zero.
		send_boards(0, 0, 0, 0);
		send_boards(2046, 2046, 2046, 2046);
		sample_ch.valid <= 1'b0;
		wait_idle();

		// With the identity range a board is just the sum of its two samples.
		load_ranges(RANGE_IDENTITY);
		send_boards(0, 0, 0, 0);
		send_boards(200, 100, 0, 50);
		send_boards(200, 198, 0, 50);
		send_boards(200, 50, 0, 100);
		send_boards(200, 150, 0, 100);
		send_boards(200, 50, 0, 197);
		send_boards(200, 50, 0, 170);
		send_boards(200, 50, 0, 169);
		send_boards(0, 300, 295, 0);
		send_boards(0, 300, 296, 0);
		send_boards(10, 10, 10, 10);
		send_boards(50, 50, 0, 0);
		send_boards(0, 0, 500, 0);
		send_boards(0, 0, 0, 2046);
		send_boards(2046, 2046, 2046, 2046);
		sample_ch.valid <= 1'b0;
		wait_idle();

		// Full-span and inverted ranges at the signed 16-bit limits.
		load_ranges(RANGE_EXTREME);
		send_boards(0, 0, 0, 0);
		send_boards(2046, 2046, 2046, 2046);
		send_boards(2046, 0, 1023, 0);
		send_boards(0, 2046, 0, 1);
		sample_ch.valid <= 1'b0;
		wait_idle();

		load_ranges(RANGE_IDENTITY);
		run_random(250);
		wait_idle();
		load_ranges(RANGE_WORDS);
		run_random(250);
		wait_idle();

		tx_idle_pct = 46;
		rx_idle_pct = 34;
		load_ranges(RANGE_NARROW);
		run_random(250);
		wait_idle();
		load_ranges(RANGE_EXTREME);
		run_random(250);
		wait_idle();

		// No idling; the receiver stalls long enough for the pipeline to back up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_ranges(RANGE_NARROW);
		fork
			hold_receiver(300);
		join_none
		run_random(250);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Checked %0d result words over %0d range settings (%0d run, %0d stop pulses).",
			sb.checked, range_sets, sb.run_count, sb.stop_count);
		if (sb.fail_count == 0 && sb.pending_turns.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.fail_count,
				sb.pending_turns.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected", sb.pending_turns.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/lstc_pkg.sv
rtl/lstc_stream_if.sv
rtl/lstc_lane.sv
rtl/lstc_merge.sv
rtl/light_seeking_turn_controller.sv
sim/tb_top.sv
